FILE: design/bmtf_pkg.sv
// Shared types and constants for the block mode move-to-front encoder.
`timescale 1ns / 1ps

package bmtf_pkg;

  localparam int NUM_MODES_DEF = 35;
  localparam int ENTRY_W       = 6;
  localparam int POS_W         = 7;
  localparam int SIZE_W        = 5;
  localparam int CODE_W        = 2;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 16;

  localparam logic [SIZE_W-1:0] SIZE_LARGE = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] SIZE_MID   = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_SMALL = SIZE_W'(4);

  localparam logic [CODE_W-1:0] CODE_SMALL = 2'd0;
  localparam logic [CODE_W-1:0] CODE_MID   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_LARGE = 2'd2;
  localparam logic [CODE_W-1:0] CODE_END   = 2'd3;

  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [ENTRY_W-1:0] mode;
    logic [POS_W-1:0]   rank;
  } cell_ctrl_t;

  function automatic logic [CODE_W-1:0] size_to_code(input logic [SIZE_W-1:0] size);
    logic [CODE_W-1:0] code;
    code = CODE_SMALL;
    if (size == SIZE_LARGE) begin
      code = CODE_LARGE;
    end else if (size == SIZE_MID) begin
      code = CODE_MID;
    end
    return code;
  endfunction

endpackage

FILE: design/bmtf_cell.sv
// One list position: holds a mode entry, compares it and shifts from its neighbor.
`timescale 1ns / 1ps

module bmtf_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmtf_pkg::cell_ctrl_t          ctrl,
  input  logic [bmtf_pkg::ENTRY_W-1:0]  prev_entry,
  input  logic [bmtf_pkg::ENTRY_W-1:0]  cmp_mode,
  output logic [bmtf_pkg::ENTRY_W-1:0]  entry,
  output logic                          match
);

  logic [bmtf_pkg::ENTRY_W-1:0] entry_r;
  logic [bmtf_pkg::ENTRY_W-1:0] entry_nxt;
  logic                         take;

  assign take = ctrl.shift && (bmtf_pkg::POS_W'(INDEX) <= ctrl.rank);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.clear) begin
      entry_nxt = bmtf_pkg::ENTRY_W'(INDEX);
    end else if (take) begin
      entry_nxt = (INDEX == 0) ? ctrl.mode : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= bmtf_pkg::ENTRY_W'(INDEX);
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
  assign match = (entry_r == cmp_mode);

endmodule

FILE: design/bmtf_rank_enc.sv
// Turn the one-hot match row into a list position, or NUM_MODES when nothing hits.
`timescale 1ns / 1ps

module bmtf_rank_enc #(
  parameter int NUM_MODES = bmtf_pkg::NUM_MODES_DEF
) (
  input  logic [NUM_MODES-1:0]        match,
  output logic [bmtf_pkg::POS_W-1:0]  pos
);

  logic [bmtf_pkg::POS_W-1:0] pos_or;

  always_comb begin
    pos_or = '0;
    for (int i = 0; i < NUM_MODES; i++) begin
      pos_or = pos_or | (match[i] ? bmtf_pkg::POS_W'(i) : '0);
    end
    pos = (|match) ? pos_or : bmtf_pkg::POS_W'(NUM_MODES);
  end

endmodule

FILE: design/block_mode_mtf_encoder.sv
// Top level of the block mode move-to-front encoder.
// Usage:
//   Input channel in_*: one request per coded block, or an end request with in_tlast
//   high. in_tdata holds block_size, mode and transform_used.
//   Output channel out_*: one result per request; out_tlast marks the terminator.
//   out_tdata holds size_code, rank, flag_valid and flag_bit.
//   Config channel cfg_*: writes post_transform_on; always ready, write while idle.
// Timing:
//   A request takes two steps: the first compares the mode against every cell of the
//   list and encodes its position, the second shifts the cells and loads the output
//   register. in_tready is high only in the first step, so a new request is taken only
//   after the shift step of the last one; that step waits while the output register is full.
// Reset:
//   rst_n (synchronous) puts the list in identity order, clears the config bit and
//   empties the output register.
// Stall:
//   While out_tready is low and a result waits, the next request is still taken and
//   encoded; it then holds, with the list unchanged, until the output register frees.
`timescale 1ns / 1ps

module block_mode_mtf_encoder #(
  parameter int NUM_MODES = bmtf_pkg::NUM_MODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,    // [0] post_transform_on
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bmtf_pkg::IN_DATA_W-1:0]    in_tdata,    // [4:0] block_size, [10:5] mode,
                                                         // [11] transform_used, rest zero
  input  logic                              in_tlast,    // kind: end of block list
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bmtf_pkg::OUT_DATA_W-1:0]   out_tdata,   // [1:0] size_code, [7:2] rank,
                                                         // [8] flag_valid, [9] flag_bit
  output logic                              out_tlast    // is_end
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SHIFT = 2'b10
  } state_t;

  state_t st_r, st_nxt;

  logic                             post_on_r;
  logic [bmtf_pkg::ENTRY_W-1:0]     mode_r;
  logic [bmtf_pkg::CODE_W-1:0]      code_r;
  logic [bmtf_pkg::POS_W-1:0]       rank_r;
  logic                             tbit_r;
  logic                             end_r;
  logic                             out_valid_r;
  logic [bmtf_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                             out_last_r;

  logic                             in_acc;
  logic                             out_free;
  logic                             commit;
  logic [bmtf_pkg::SIZE_W-1:0]      in_size;
  logic [bmtf_pkg::ENTRY_W-1:0]     in_mode;
  logic [NUM_MODES-1:0]             match;
  logic [bmtf_pkg::ENTRY_W-1:0]     entries [NUM_MODES];
  logic [bmtf_pkg::POS_W-1:0]       pos;
  logic                             found;
  bmtf_pkg::cell_ctrl_t             ctrl;
  logic                             flag_valid;
  logic                             flag_bit;
  logic [bmtf_pkg::ENTRY_W-1:0]     rank_out;

  assign in_size   = in_tdata[4:0];
  assign in_mode   = in_tdata[10:5];
  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (st_r == ST_SHIFT) && out_free;
  assign found     = (rank_r < bmtf_pkg::POS_W'(NUM_MODES));

  assign ctrl.clear = commit && end_r;
  assign ctrl.shift = commit && !end_r && found;
  assign ctrl.mode  = mode_r;
  assign ctrl.rank  = rank_r;

  for (genvar k = 0; k < NUM_MODES; k++) begin : g_cell
    bmtf_cell #(
      .INDEX(k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry ((k == 0) ? mode_r : entries[(k == 0) ? 0 : k - 1]),
      .cmp_mode   (in_mode),
      .entry      (entries[k]),
      .match      (match[k])
    );
  end

  bmtf_rank_enc #(
    .NUM_MODES(NUM_MODES)
  ) u_rank_enc (
    .match (match),
    .pos   (pos)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign flag_valid = !end_r && post_on_r;
  assign flag_bit   = flag_valid && tbit_r;
  assign rank_out   = end_r ? '0 : rank_r[bmtf_pkg::ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      post_on_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        post_on_r <= cfg_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      code_r <= bmtf_pkg::size_to_code(in_size);
      rank_r <= pos;
      tbit_r <= in_tdata[11];
      end_r  <= in_tlast;
    end
    if (commit) begin
      out_data_r <= {6'b0, flag_bit, flag_valid, rank_out,
                     end_r ? bmtf_pkg::CODE_END : code_r};
      out_last_r <= end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_match_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one list entry matches the mode");

  a_accept_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r == ST_SHIFT))
    else $error("accepted request did not enter the shift step");

  a_clear_identity: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (entries[0] == '0) && out_tlast && out_tvalid)
    else $error("end request did not restore the list front or flag the terminator");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[9:2] == '0))
    else $error("terminator result carries rank or flag bits");

  a_shift_front: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> (entries[0] == $past(mode_r)))
    else $error("mode did not move to the front of the list");

endmodule

FILE: verif/tb_block_mode_mtf_encoder.sv
// Testbench for the block mode move-to-front encoder: directed table, random sequences, scoreboard.
`timescale 1ns / 1ps

module tb_block_mode_mtf_encoder;

  localparam int          MODE_CNT    = bmtf_pkg::NUM_MODES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic        KIND_BLOCK  = 1'b0;
  localparam logic        KIND_END    = 1'b1;

  localparam logic [bmtf_pkg::CODE_W-1:0] CODE_SMALL = bmtf_pkg::CODE_SMALL;
  localparam logic [bmtf_pkg::CODE_W-1:0] CODE_MID   = bmtf_pkg::CODE_MID;
  localparam logic [bmtf_pkg::CODE_W-1:0] CODE_LARGE = bmtf_pkg::CODE_LARGE;
  localparam logic [bmtf_pkg::CODE_W-1:0] CODE_END   = bmtf_pkg::CODE_END;

  typedef struct packed {
    logic [bmtf_pkg::CODE_W-1:0] size_code;
    logic [5:0]                  rank;
    logic                        flag_valid;
    logic                        flag_bit;
    logic                        is_end;
  } blk_sym_t;

  typedef struct packed {
    logic                        cfg_wr;
    logic                        cfg_val;
    logic                        kind;
    logic [bmtf_pkg::SIZE_W-1:0] bsize;
    logic [5:0]                  mode;
    logic                        tbit;
    logic                        typed;
    blk_sym_t                    sym;
  } dir_row_t;

  localparam blk_sym_t NO_SYM = '0;
  localparam int       DIR_N  = 17;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, 1'b0, KIND_BLOCK, 5'd16, 6'd0,  1'b0, 1'b1, '{CODE_LARGE, 6'd0,  1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd4,  6'd34, 1'b1, 1'b1, '{CODE_SMALL, 6'd34, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd31, 6'd63, 1'b1, 1'b1, '{CODE_SMALL, 6'd35, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd8,  6'd34, 1'b0, 1'b1, '{CODE_MID,   6'd0,  1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd0,  6'd0,  1'b0, 1'b0, NO_SYM},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd16, 6'd35, 1'b0, 1'b1, '{CODE_LARGE, 6'd35, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd12, 6'd20, 1'b1, 1'b0, NO_SYM},
    '{1'b0, 1'b0, KIND_END,   5'd16, 6'd34, 1'b1, 1'b1, '{CODE_END,   6'd0,  1'b0, 1'b0, 1'b1}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd4,  6'd34, 1'b1, 1'b1, '{CODE_SMALL, 6'd34, 1'b0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, KIND_BLOCK, 5'd16, 6'd0,  1'b1, 1'b0, NO_SYM},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd8,  6'd42, 1'b0, 1'b1, '{CODE_MID,   6'd35, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, KIND_END,   5'd31, 6'd63, 1'b1, 1'b1, '{CODE_END,   6'd0,  1'b0, 1'b0, 1'b1}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd4,  6'd7,  1'b1, 1'b1, '{CODE_SMALL, 6'd7,  1'b1, 1'b1, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd8,  6'd7,  1'b1, 1'b1, '{CODE_MID,   6'd0,  1'b1, 1'b1, 1'b0}},
    '{1'b0, 1'b0, KIND_BLOCK, 5'd2,  6'd33, 1'b0, 1'b0, NO_SYM},
    '{1'b1, 1'b0, KIND_BLOCK, 5'd16, 6'd1,  1'b1, 1'b0, NO_SYM},
    '{1'b0, 1'b0, KIND_END,   5'd0,  6'd0,  1'b0, 1'b1, '{CODE_END,   6'd0,  1'b0, 1'b0, 1'b1}}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bmtf_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bmtf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  logic [5:0]  mode_list [MODE_CNT];
  logic        post_xform_en;
  blk_sym_t    sym_q [$];
  int          err_cnt;
  int          gap_odds;
  int          stall_odds;
  int unsigned cycle_cnt;

  block_mode_mtf_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void restore_mode_order();
    int k;
    for (k = 0; k < MODE_CNT; k++) mode_list[k] = k[5:0];
  endfunction

  function automatic blk_sym_t encode_block(input logic kind,
                                            input logic [bmtf_pkg::SIZE_W-1:0] bsize,
                                            input logic [5:0] mode, input logic tbit);
    blk_sym_t s;
    int       pos;
    int       k;
    s = '0;
    if (kind == KIND_END) begin
      s.size_code = CODE_END;
      s.is_end    = 1'b1;
      restore_mode_order();
      return s;
    end
    pos = MODE_CNT;
    for (k = 0; k < MODE_CNT; k++) begin
      if (pos == MODE_CNT && mode_list[k] == mode) pos = k;
    end
    if (pos < MODE_CNT) begin
      for (k = pos; k > 0; k--) mode_list[k] = mode_list[k-1];
      mode_list[0] = mode;
    end
    case (bsize)
      bmtf_pkg::SIZE_LARGE: s.size_code = CODE_LARGE;
      bmtf_pkg::SIZE_MID:   s.size_code = CODE_MID;
      default:              s.size_code = CODE_SMALL;
    endcase
    s.rank       = pos[5:0];
    s.flag_valid = post_xform_en;
    s.flag_bit   = post_xform_en & tbit;
    return s;
  endfunction

  task automatic send_request(input logic kind, input logic [bmtf_pkg::SIZE_W-1:0] bsize,
                              input logic [5:0] mode, input logic tbit,
                              input logic typed, input blk_sym_t typed_sym);
    int       n;
    blk_sym_t s;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, tbit, mode, bsize};
    in_tlast  <= kind;
    do @(posedge clk); while (!in_tready);
    s = encode_block(kind, bsize, mode, tbit);
    sym_q.push_back(typed ? typed_sym : s);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sym_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_post_xform(input logic val);
    settle_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    post_xform_en = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stall_gen
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        n = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    blk_sym_t want;
    blk_sym_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[7:2], out_tdata[8], out_tdata[9], out_tlast};
      if (sym_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = sym_q.pop_front();
        if (got.size_code != want.size_code) begin
          $display("%0t: size_code expected %0d actual %0d", $time, want.size_code,
                   got.size_code);
          err_cnt++;
        end
        if (got.rank != want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
          err_cnt++;
        end
        if (got.flag_valid != want.flag_valid) begin
          $display("%0t: flag_valid expected %0d actual %0d", $time, want.flag_valid,
                   got.flag_valid);
          err_cnt++;
        end
        if (got.flag_bit != want.flag_bit) begin
          $display("%0t: flag_bit expected %0d actual %0d", $time, want.flag_bit,
                   got.flag_bit);
          err_cnt++;
        end
        if (got.is_end != want.is_end) begin
          $display("%0t: is_end expected %0d actual %0d", $time, want.is_end, got.is_end);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL block_mode_mtf_encoder");
      $finish;
    end
  end

  initial begin
    int                          i;
    int                          p;
    int                          cnt;
    int                          len;
    int                          j;
    logic [bmtf_pkg::SIZE_W-1:0] bs;
    logic [5:0]                  md;
    err_cnt       = 0;
    cycle_cnt     = 0;
    post_xform_en = 1'b0;
    gap_odds      = 4;
    stall_odds    = 4;
    restore_mode_order();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].cfg_wr) write_post_xform(DIR_ROWS[i].cfg_val);
      send_request(DIR_ROWS[i].kind, DIR_ROWS[i].bsize, DIR_ROWS[i].mode, DIR_ROWS[i].tbit,
                   DIR_ROWS[i].typed, DIR_ROWS[i].sym);
    end

    for (p = 0; p < 6; p++) begin
      write_post_xform(p % 2 == 0);
      if (p == 2 || p == 5) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(2, 8);
        stall_odds = $urandom_range(2, 8);
      end
      cnt = 0;
      while (cnt < 280) begin
        len = $urandom_range(1, 40);
        for (j = 0; j < len; j++) begin
          if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 2))
              0:       bs = bmtf_pkg::SIZE_SMALL;
              1:       bs = bmtf_pkg::SIZE_MID;
              default: bs = bmtf_pkg::SIZE_LARGE;
            endcase
            md = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 4))
                                             : 6'($urandom_range(0, MODE_CNT - 1));
          end else begin
            bs = bmtf_pkg::SIZE_W'($urandom_range(0, 31));
            md = 6'($urandom_range(0, 63));
          end
          send_request(KIND_BLOCK, bs, md, 1'($urandom_range(0, 1)), 1'b0, NO_SYM);
          cnt++;
          if ($urandom_range(0, 199) == 0) settle_idle();
        end
        if ($urandom_range(0, 9) != 0) begin
          send_request(KIND_END, bmtf_pkg::SIZE_W'($urandom_range(0, 31)),
                       6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0, NO_SYM);
          cnt++;
        end
      end
    end

    settle_idle();
    if (err_cnt == 0) begin
      $display("PASS block_mode_mtf_encoder");
    end else begin
      $display("FAIL block_mode_mtf_encoder");
    end
    $finish;
  end

endmodule
